// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AGDN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AGDN_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define AGDN_ASSERT(lbl, clk, rst, prop, msg)
`define AGDN_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: hw/rtl/agdn_pkg.sv
// ----------------------------------------------------------------------------
// agdn_pkg
// Shared types and constants of the Anscombe-domain 5x5 Gaussian denoiser.
// ----------------------------------------------------------------------------
package agdn_pkg;

   localparam int IMG_WIDTH   = 256;
   localparam int IMG_HEIGHT  = 256;
   localparam int COL_W       = $clog2(IMG_WIDTH);
   localparam int ROW_W       = $clog2(IMG_HEIGHT);
   localparam int STORE_DEPTH = 5 * IMG_WIDTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int REF_W       = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;
   localparam int ACC_W       = 26;
   localparam int WSUM_W      = 21;
   localparam int CSR_ADDR_W  = 5;

   // floor(x/5) = (x * 3277) >> 14 for x < 4096
   localparam int RECIP5    = 3277;
   localparam int RECIP5_SH = 14;

   localparam logic [2:0] REG_CORNER     = 3'd0;
   localparam logic [2:0] REG_OUTER_NEAR = 3'd1;
   localparam logic [2:0] REG_OUTER_MID  = 3'd2;
   localparam logic [2:0] REG_INNER_DIAG = 3'd3;
   localparam logic [2:0] REG_INNER_SIDE = 3'd4;
   localparam logic [2:0] REG_CENTRE     = 3'd5;
   localparam logic [2:0] REG_INV_MODE   = 3'd6;

   typedef struct packed {
      logic [7:0] pixel_in;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] coef_corner;
      logic [15:0] coef_outer_near;
      logic [15:0] coef_outer_mid;
      logic [15:0] coef_inner_diag;
      logic [15:0] coef_inner_side;
      logic [15:0] coef_centre;
      logic        inverse_mode;
   } cfg_type;

   typedef struct packed {
      logic       accept;
      logic       clear;
      logic       tap_valid;
      logic       tap_last;
      logic [2:0] tap_r;
      logic [2:0] tap_c;
      logic       div_step;
      logic [2:0] div_bit;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic out_ready;
      logic mac_done;
      logic out_free;
   } sts_type;

endpackage

// File: hw/rtl/anscombe_gaussian_denoise_5x5.sv
// ----------------------------------------------------------------------------
// anscombe_gaussian_denoise_5x5
// Streaming Anscombe-domain 5x5 Gaussian denoiser for grey frames.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one beat per pixel in raster order; a beat with flush set
//   carries no pixel and only lets a pending output out. rsp_* returns the
//   denoised pixels in raster order, frame_last on the frame's final pixel.
//   Outputs trail the input by about two rows and two columns; after the
//   last input pixel, flush beats drain the remaining outputs, one each.
//   csr_* is an APB port holding the six Q0.16 kernel weights and the
//   inverse mode; write it only while the block is idle.
// Sequence:
//   A beat that yields no output only passes the readiness check. A beat
//   that yields an output walks the window: the 25 window taps are read one per cycle
//   from the single read port of the line store and summed by one MAC,
//   then restoring division steps, one quotient bit each, and the output step follow.
// Reset clears counters and loads the default weights; the line store is
//   not cleared. A result waits in the output register while rsp_ready is
//   low; the next beat is taken meanwhile and its result then waits for it.
// ----------------------------------------------------------------------------
module anscombe_gaussian_denoise_5x5 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  agdn_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output agdn_pkg::rsp_type                rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [agdn_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   agdn_pkg::cfg_type cfg;
   agdn_pkg::cmd_type cmd;
   agdn_pkg::sts_type sts;

   agdn_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   agdn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   agdn_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hw/rtl/agdn_csr.sv
// ----------------------------------------------------------------------------
// agdn_csr
// APB register file: kernel weights and inverse transform mode.
// ----------------------------------------------------------------------------
module agdn_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [agdn_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output agdn_pkg::cfg_type                cfg
);

   agdn_pkg::cfg_type cfg_ff;
   logic [2:0]        idx;
   logic              wr;

   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_corner     <= 16'd247;
         cfg_ff.coef_outer_near <= 16'd984;
         cfg_ff.coef_outer_mid  <= 16'd1559;
         cfg_ff.coef_inner_diag <= 16'd3926;
         cfg_ff.coef_inner_side <= 16'd6220;
         cfg_ff.coef_centre     <= 16'd9853;
         cfg_ff.inverse_mode    <= 1'b0;
      end else if (wr) begin
         case (idx)
            agdn_pkg::REG_CORNER:     cfg_ff.coef_corner     <= csr_pwdata[15:0];
            agdn_pkg::REG_OUTER_NEAR: cfg_ff.coef_outer_near <= csr_pwdata[15:0];
            agdn_pkg::REG_OUTER_MID:  cfg_ff.coef_outer_mid  <= csr_pwdata[15:0];
            agdn_pkg::REG_INNER_DIAG: cfg_ff.coef_inner_diag <= csr_pwdata[15:0];
            agdn_pkg::REG_INNER_SIDE: cfg_ff.coef_inner_side <= csr_pwdata[15:0];
            agdn_pkg::REG_CENTRE:     cfg_ff.coef_centre     <= csr_pwdata[15:0];
            agdn_pkg::REG_INV_MODE:   cfg_ff.inverse_mode    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         agdn_pkg::REG_CORNER:     csr_prdata = {16'd0, cfg_ff.coef_corner};
         agdn_pkg::REG_OUTER_NEAR: csr_prdata = {16'd0, cfg_ff.coef_outer_near};
         agdn_pkg::REG_OUTER_MID:  csr_prdata = {16'd0, cfg_ff.coef_outer_mid};
         agdn_pkg::REG_INNER_DIAG: csr_prdata = {16'd0, cfg_ff.coef_inner_diag};
         agdn_pkg::REG_INNER_SIDE: csr_prdata = {16'd0, cfg_ff.coef_inner_side};
         agdn_pkg::REG_CENTRE:     csr_prdata = {16'd0, cfg_ff.coef_centre};
         agdn_pkg::REG_INV_MODE:   csr_prdata = {31'd0, cfg_ff.inverse_mode};
         default:                  csr_prdata = 32'd0;
      endcase
   end

endmodule

// File: hw/rtl/agdn_ctrl.sv
// ----------------------------------------------------------------------------
// agdn_ctrl
// Sequencer: accept, readiness check, 25-tap walk, quotient steps, emit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module agdn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  agdn_pkg::sts_type sts,
   output agdn_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_TAPS, ST_WAIT, ST_DIV, ST_FIN
   } state_type;

   state_type  state_ff;
   logic [2:0] tap_r_ff;
   logic [2:0] tap_c_ff;
   logic [2:0] div_bit_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.accept    = req_valid && req_ready;
      cmd.clear     = (state_ff == ST_CHECK);
      cmd.tap_valid = (state_ff == ST_TAPS);
      cmd.tap_r     = tap_r_ff;
      cmd.tap_c     = tap_c_ff;
      cmd.tap_last  = (tap_r_ff == 3'd4) && (tap_c_ff == 3'd4);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.div_bit   = div_bit_ff;
      cmd.emit      = (state_ff == ST_FIN) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tap_r_ff   <= 3'd0;
         tap_c_ff   <= 3'd0;
         div_bit_ff <= 3'd4;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               tap_r_ff <= 3'd0;
               tap_c_ff <= 3'd0;
               state_ff <= sts.out_ready ? ST_TAPS : ST_IDLE;
            end
            ST_TAPS: begin
               if (tap_c_ff == 3'd4) begin
                  tap_c_ff <= 3'd0;
                  tap_r_ff <= tap_r_ff + 3'd1;
               end else begin
                  tap_c_ff <= tap_c_ff + 3'd1;
               end
               if (cmd.tap_last) state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               div_bit_ff <= 3'd4;
               if (sts.mac_done) state_ff <= ST_DIV;
            end
            ST_DIV: begin
               div_bit_ff <= div_bit_ff - 3'd1;
               if (div_bit_ff == 3'd0) state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (sts.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `AGDN_NEVER(a_mac_done_in_wait, clock, reset, sts.mac_done && (state_ff != ST_WAIT), "mac done outside wait")
   `AGDN_NEVER(a_emit_when_free, clock, reset, cmd.emit && !sts.out_free, "emit into busy output")
   `AGDN_ASSERT(a_accept_to_check, clock, reset, cmd.accept |=> (state_ff == ST_CHECK), "accept not followed by check")

endmodule

// File: hw/rtl/agdn_datapath.sv
// ----------------------------------------------------------------------------
// agdn_datapath
// Line store, position counters, tap address pipeline, MAC, divider, output.
// ----------------------------------------------------------------------------
module agdn_datapath (
   input  logic              clock,
   input  logic              reset,
   input  agdn_pkg::cfg_type cfg,
   input  agdn_pkg::cmd_type cmd,
   output agdn_pkg::sts_type sts,
   input  agdn_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output agdn_pkg::rsp_type rsp_payload
);

   localparam int RW = agdn_pkg::REF_W;
   localparam int CW = agdn_pkg::COL_W;
   localparam int HW = agdn_pkg::ROW_W;
   localparam int AW = agdn_pkg::ADDR_W;

   function automatic logic [4:0] fwd_anscombe(input logic [7:0] x);
      logic [9:0] t;
      logic [4:0] a;
      t = {x, 2'b01};
      a = 5'd0;
      for (int k = 1; k < 32; k++) begin
         if (10'(k * k) <= t) a = 5'(k);
      end
      return a;
   endfunction

   function automatic logic [RW-1:0] reflect(input logic signed [RW-1:0] k,
                                             input logic signed [RW-1:0] n);
      logic signed [RW-1:0] m;
      m = (k < 0) ? -k : k;
      if (m >= n) m = (n <<< 1) - RW'(2) - m;
      return m;
   endfunction

   function automatic logic [1:0] tap_dist(input logic [2:0] t);
      return (t < 3'd2) ? 2'(3'd2 - t) : 2'(t - 3'd2);
   endfunction

   logic [4:0] mem [agdn_pkg::STORE_DEPTH];

   logic [CW-1:0] in_col_ff, out_col_ff;
   logic [HW-1:0] in_row_ff, out_row_ff;
   logic [2:0]    in_m5_ff;
   logic          full_ff;

   // tap pipeline
   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic          s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;
   logic [HW-1:0] s1_row_ff;
   logic [CW-1:0] s1_col_ff, s2_col_ff;
   logic [2:0]    s2_m5_ff;
   logic [AW-1:0] s3_addr_ff;
   logic [15:0]   s1_w_ff, s2_w_ff, s3_w_ff, s4_w_ff;
   logic [4:0]    rd_ff;

   logic [agdn_pkg::ACC_W-1:0]  acc_ff;
   logic [agdn_pkg::WSUM_W-1:0] wsum_ff;
   logic [4:0]                  quo_ff;
   logic                        mac_done_ff;
   logic                        rsp_valid_ff;
   agdn_pkg::rsp_type           rsp_ff;

   logic [HW-1:0] need_r;
   logic [CW-1:0] need_c;
   logic          frame_last;
   logic          store_wr;
   logic [AW-1:0] wr_addr;

   logic signed [RW-1:0] k_row, k_col;
   logic [1:0]    dist_r, dist_c, d_lo, d_hi;
   logic [15:0]   w_sel;
   logic [HW+11:0] prod5;
   logic [HW-1:0]  quot5;

   logic [agdn_pkg::ACC_W-1:0] div_sub;
   logic [agdn_pkg::ACC_W:0]   div_trial;

   logic [4:0]  y;
   logic [10:0] y2, bias;
   logic [7:0]  pix_inv;

   // readiness of the next output position
   always_comb begin
      need_r = (32'(out_row_ff) + 2 < agdn_pkg::IMG_HEIGHT - 1) ?
               HW'(out_row_ff + HW'(2)) : HW'(agdn_pkg::IMG_HEIGHT - 1);
      need_c = (32'(out_col_ff) + 2 < agdn_pkg::IMG_WIDTH - 1) ?
               CW'(out_col_ff + CW'(2)) : CW'(agdn_pkg::IMG_WIDTH - 1);
      sts.out_ready = full_ff || (in_row_ff > need_r) ||
                      ((in_row_ff == need_r) && (in_col_ff > need_c));
      sts.mac_done  = mac_done_ff;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign frame_last = (out_row_ff == HW'(agdn_pkg::IMG_HEIGHT - 1)) &&
                       (out_col_ff == CW'(agdn_pkg::IMG_WIDTH - 1));
   assign store_wr   = cmd.accept && !req_payload.flush && !full_ff;
   assign wr_addr    = AW'(in_m5_ff) * AW'(agdn_pkg::IMG_WIDTH) + AW'(in_col_ff);

   // stage 0: mirrored position and weight class
   always_comb begin
      k_row  = RW'(out_row_ff) + RW'(cmd.tap_r) - RW'(2);
      k_col  = RW'(out_col_ff) + RW'(cmd.tap_c) - RW'(2);
      dist_r = tap_dist(cmd.tap_r);
      dist_c = tap_dist(cmd.tap_c);
      d_lo   = (dist_r < dist_c) ? dist_r : dist_c;
      d_hi   = (dist_r < dist_c) ? dist_c : dist_r;
      if (d_hi == 2'd0)      w_sel = cfg.coef_centre;
      else if (d_hi == 2'd1) w_sel = (d_lo == 2'd0) ? cfg.coef_inner_side : cfg.coef_inner_diag;
      else if (d_lo == 2'd0) w_sel = cfg.coef_outer_mid;
      else if (d_lo == 2'd1) w_sel = cfg.coef_outer_near;
      else                   w_sel = cfg.coef_corner;
   end

   assign prod5 = (HW+12)'(s1_row_ff) * (HW+12)'(agdn_pkg::RECIP5);
   assign quot5 = HW'(prod5 >> agdn_pkg::RECIP5_SH);

   assign div_sub   = agdn_pkg::ACC_W'(wsum_ff) << cmd.div_bit;
   assign div_trial = {1'b0, acc_ff} - {1'b0, div_sub};

   always_comb begin
      y    = (wsum_ff == '0) ? 5'd0 : quo_ff;
      y2   = (11'(y) * 11'(y)) << 1;
      bias = cfg.inverse_mode ? 11'd3 : 11'd1;
      pix_inv = (y2 < bias) ? 8'd0 : 8'((y2 - bias) >> 3);
   end

   always_ff @(posedge clock) begin
      if (store_wr) mem[wr_addr] <= fwd_anscombe(req_payload.pixel_in);
      rd_ff <= mem[s3_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_m5_ff   <= 3'd0;
         full_ff    <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (cmd.emit && frame_last) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_m5_ff   <= 3'd0;
         full_ff    <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         if (store_wr) begin
            if (in_col_ff == CW'(agdn_pkg::IMG_WIDTH - 1)) begin
               in_col_ff <= '0;
               if (in_row_ff == HW'(agdn_pkg::IMG_HEIGHT - 1)) begin
                  in_row_ff <= '0;
                  in_m5_ff  <= 3'd0;
                  full_ff   <= 1'b1;
               end else begin
                  in_row_ff <= in_row_ff + HW'(1);
                  in_m5_ff  <= (in_m5_ff == 3'd4) ? 3'd0 : in_m5_ff + 3'd1;
               end
            end else begin
               in_col_ff <= in_col_ff + CW'(1);
            end
         end
         if (cmd.emit) begin
            if (out_col_ff == CW'(agdn_pkg::IMG_WIDTH - 1)) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + HW'(1);
            end else begin
               out_col_ff <= out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         mac_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.tap_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         mac_done_ff <= s4_valid_ff && s4_last_ff;
         if (cmd.emit)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= cmd.tap_last;
      s1_row_ff  <= HW'(reflect(k_row, RW'(agdn_pkg::IMG_HEIGHT)));
      s1_col_ff  <= CW'(reflect(k_col, RW'(agdn_pkg::IMG_WIDTH)));
      s1_w_ff    <= w_sel;

      s2_last_ff <= s1_last_ff;
      s2_m5_ff   <= 3'(s1_row_ff - HW'(quot5 * HW'(5)));
      s2_col_ff  <= s1_col_ff;
      s2_w_ff    <= s1_w_ff;

      s3_last_ff <= s2_last_ff;
      s3_addr_ff <= AW'(s2_m5_ff) * AW'(agdn_pkg::IMG_WIDTH) + AW'(s2_col_ff);
      s3_w_ff    <= s2_w_ff;

      s4_last_ff <= s3_last_ff;
      s4_w_ff    <= s3_w_ff;

      if (cmd.clear) begin
         acc_ff  <= '0;
         wsum_ff <= '0;
         quo_ff  <= 5'd0;
      end else if (s4_valid_ff) begin
         acc_ff  <= acc_ff + agdn_pkg::ACC_W'(s4_w_ff) * agdn_pkg::ACC_W'(rd_ff);
         wsum_ff <= wsum_ff + agdn_pkg::WSUM_W'(s4_w_ff);
      end else if (cmd.div_step && !div_trial[agdn_pkg::ACC_W]) begin
         acc_ff <= div_trial[agdn_pkg::ACC_W-1:0];
         quo_ff[cmd.div_bit] <= 1'b1;
      end

      if (cmd.emit) begin
         rsp_ff.pixel_out  <= pix_inv;
         rsp_ff.frame_last <= frame_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
